### rtl/core/mtae_pkg.sv
// Shared types, constants and character functions for the marker text ANSI expander.
package mtae_pkg;

    localparam logic [7:0] MARK_JUMP   = 8'hE0;
    localparam logic [7:0] MARK_STYLE  = 8'hE1;
    localparam logic [7:0] STYLE_RESET = 8'hFF;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_M        = 8'h6D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    // Command kinds passed from front to back
    localparam logic [1:0] CMD_SINGLE   = 2'd0;
    localparam logic [1:0] CMD_STYLE    = 2'd1;
    localparam logic [1:0] CMD_STYLE_RS = 2'd2;

    localparam logic [2:0] STYLE_LAST    = 3'd6;
    localparam logic [2:0] STYLE_RS_LAST = 3'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] count;
        logic       eos;
    } cmd_t;

    function automatic logic [7:0] mod_char(input logic [1:0] sel);
        logic [7:0] ch;
        case (sel)
            2'd0:    ch = CH_ZERO + 8'd3;
            2'd1:    ch = CH_ZERO + 8'd4;
            2'd2:    ch = CH_ZERO + 8'd7;
            default: ch = CH_ZERO + 8'd9;
        endcase
        return ch;
    endfunction

    // Character at a given step of the seven-byte style sequence
    function automatic logic [7:0] style_char(input logic [7:0] b, input logic [2:0] step);
        logic [7:0] ch;
        case (step)
            3'd0:    ch = CH_ESC;
            3'd1:    ch = CH_LBRACKET;
            3'd2:    ch = CH_ZERO + {5'd0, b[7:5]};
            3'd3:    ch = CH_SEMI;
            3'd4:    ch = mod_char(b[1:0]);
            3'd5:    ch = CH_ZERO + {5'd0, b[4:2]};
            default: ch = CH_M;
        endcase
        return ch;
    endfunction

    // Character at a given step of the four-byte reset sequence
    function automatic logic [7:0] reset_char(input logic [2:0] step);
        logic [7:0] ch;
        case (step)
            3'd0:    ch = CH_ESC;
            3'd1:    ch = CH_LBRACKET;
            3'd2:    ch = CH_ZERO;
            default: ch = CH_M;
        endcase
        return ch;
    endfunction

endpackage

### rtl/core/mtae_front.sv
// Front end: tracks pending markers and turns input bytes into commands.
module mtae_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                q_full,
    output logic                in_ready,
    output logic                push,
    output mtae_pkg::cmd_t      push_cmd
);

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_JUMP  = 2'd1;
    localparam logic [1:0] PEND_STYLE = 2'd2;

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       has_cmd;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && has_cmd;

    always_comb begin
        pend_next      = PEND_NONE;
        has_cmd        = 1'b0;
        push_cmd.kind  = mtae_pkg::CMD_SINGLE;
        push_cmd.data  = in_byte;
        push_cmd.count = 8'd1;
        push_cmd.eos   = 1'b0;
        case (pend_reg)
            PEND_JUMP: begin
                has_cmd        = (in_byte != 8'd0);
                push_cmd.data  = mtae_pkg::CH_SPACE;
                push_cmd.count = in_byte;
            end
            PEND_STYLE: begin
                has_cmd       = (in_byte != 8'd0);
                push_cmd.kind = (in_byte == mtae_pkg::STYLE_RESET) ?
                                mtae_pkg::CMD_STYLE_RS : mtae_pkg::CMD_STYLE;
            end
            default: begin
                if (in_byte == mtae_pkg::MARK_JUMP) begin
                    pend_next = PEND_JUMP;
                end else if (in_byte == mtae_pkg::MARK_STYLE) begin
                    pend_next = PEND_STYLE;
                end else if (in_byte == 8'd0) begin
                    has_cmd        = 1'b1;
                    push_cmd.count = 8'd0;
                    push_cmd.eos   = 1'b1;
                end else begin
                    has_cmd = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= PEND_NONE;
        end else if (accept) begin
            pend_reg <= pend_next;
        end
    end

endmodule

### rtl/core/mtae_queue.sv
// Short command queue between front and back.
module mtae_queue #(
    parameter int Depth = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mtae_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output mtae_pkg::cmd_t head_cmd
);

    localparam int PtrW = (Depth > 2) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    mtae_pkg::cmd_t mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;

    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    assign full       = (cnt_reg == CntW'(Depth));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + CntW'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - CntW'(1);
            end
        end
    end

endmodule

### rtl/core/mtae_back.sv
// Back end: expands queued commands into result items behind an output register.
module mtae_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  mtae_pkg::cmd_t head_cmd,
    output logic           pop,
    input  logic           out_ready,
    output logic           out_valid,
    output logic [7:0]     out_byte,
    output logic [7:0]     out_count,
    output logic           out_last,
    output logic           out_eos
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [7:0] count_reg;
    logic       last_reg;
    logic       eos_reg;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       load;
    logic [7:0] item_byte;
    logic [7:0] item_count;
    logic       item_last;
    logic       item_eos;

    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && item_last;

    always_comb begin
        item_byte  = head_cmd.data;
        item_count = head_cmd.count;
        item_last  = 1'b1;
        item_eos   = head_cmd.eos;
        case (head_cmd.kind)
            mtae_pkg::CMD_STYLE: begin
                item_byte  = mtae_pkg::style_char(head_cmd.data, step_reg);
                item_count = 8'd1;
                item_last  = (step_reg == mtae_pkg::STYLE_LAST);
                item_eos   = 1'b0;
            end
            mtae_pkg::CMD_STYLE_RS: begin
                item_byte  = mtae_pkg::reset_char(step_reg);
                item_count = 8'd1;
                item_last  = (step_reg == mtae_pkg::STYLE_RS_LAST);
                item_eos   = 1'b0;
            end
            default: begin
            end
        endcase
        step_next = item_last ? 3'd0 : step_reg + 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= 3'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                step_reg  <= step_next;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg  <= item_byte;
            count_reg <= item_count;
            last_reg  <= item_last;
            eos_reg   <= item_eos;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_count = count_reg;
    assign out_last  = last_reg;
    assign out_eos   = eos_reg;

endmodule

### rtl/core/marker_text_ansi_expander.sv
// Path: an accepted input byte is written into the command queue; its first result is then
// loaded into the output register and presented from there. Throughput: one input byte per
// cycle unless the queue is full; one result item per cycle from the output register while
// m_tready is high and a command waits. A style byte makes the back end emit four or seven
// items; the command queue (QUEUE_DEPTH entries) lets the front keep accepting bytes meanwhile.
// Reset: synchronous active-low aresetn clears pending marker, queue and output valid.
module marker_text_ansi_expander #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] repeat_count
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // [0] end_of_string
);

    logic           q_full;
    logic           push;
    mtae_pkg::cmd_t push_cmd;
    logic           pop;
    logic           head_valid;
    mtae_pkg::cmd_t head_cmd;
    logic [7:0]     out_byte;
    logic [7:0]     out_count;

    // Front: decode markers, hold the pending-marker state, emit one command per
    // byte that produces output. Marker bytes and a zero byte after a marker emit nothing.
    mtae_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .q_full   (q_full),
        .in_ready (s_tready),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Queue: decouple the front (one byte per cycle if not full) from multi-item style expansion.
    mtae_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back: step through each command's items and advance into the output register
    // whenever it is empty or being drained in the same cycle.
    mtae_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_byte   (out_byte),
        .out_count  (out_count),
        .out_last   (m_tlast),
        .out_eos    (m_tuser)
    );

    assign m_tdata = {out_count, out_byte};

endmodule
